FILE: rtl/knhv_pkg.sv
// ----------------------------------------------------------------------------
// knhv_pkg
// Shared constants, types and helpers of the k-nearest heap vote block.
// ----------------------------------------------------------------------------
package knhv_pkg;

   localparam int NEIGHBOR_COUNT = 15;
   localparam int HEAP_SLOTS     = NEIGHBOR_COUNT + 1;
   localparam int IDX_W          = $clog2(HEAP_SLOTS);
   localparam int CNT_W          = $clog2(HEAP_SLOTS);
   localparam int MODE_W         = 2;
   localparam int DIST_W         = 32;
   localparam int CLASS_W        = 8;
   localparam int VOTE_W         = 6;

   typedef logic [IDX_W-1:0] idx_type;

   localparam idx_type LAST_IDX = IDX_W'(NEIGHBOR_COUNT);

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_ELECT  = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT,
      ST_SIFT,
      ST_E_NEXT,
      ST_E_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [DIST_W-1:0]  distance;
      logic [CLASS_W-1:0] cls;
   } slot_type;

   typedef struct packed {
      logic    descend;
      logic    pick_right;
      idx_type pick;
   } sift_ctl_type;

   function automatic idx_type child_left(idx_type node);
      child_left = IDX_W'({node, 1'b1});
   endfunction

   function automatic idx_type child_right(idx_type node);
      child_right = IDX_W'({node, 1'b1} + (IDX_W + 1)'(1));
   endfunction

endpackage

FILE: rtl/knhv_req_if.sv
// ----------------------------------------------------------------------------
// knhv_req_if
// Request channel: one beat carries an operation with its distance and class.
// ----------------------------------------------------------------------------
interface knhv_req_if;
   import knhv_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [MODE_W-1:0]      mode;
   logic [DIST_W-1:0]      distance;
   logic [CLASS_W-1:0]     class_id;

   modport source (output valid, mode, distance, class_id, input ready);
   modport sink   (input valid, mode, distance, class_id, output ready);
endinterface

FILE: rtl/knhv_rsp_if.sv
// ----------------------------------------------------------------------------
// knhv_rsp_if
// Response channel: one beat per request with the insert and vote results.
// ----------------------------------------------------------------------------
interface knhv_rsp_if;
   import knhv_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   accepted;
   logic [CLASS_W-1:0]     winner_class;
   logic [VOTE_W-1:0]      vote_count;
   logic                   found;

   modport source (output valid, accepted, winner_class, vote_count, found, input ready);
   modport sink   (input valid, accepted, winner_class, vote_count, found, output ready);
endinterface

FILE: rtl/k_nearest_heap_vote.sv
// ----------------------------------------------------------------------------
// k_nearest_heap_vote
// Bounded max-heap of the nearest candidates with a majority class vote.
// ----------------------------------------------------------------------------
// The heap entries live in one synchronous memory with two read ports and a
// valid flag per slot in flip-flops, so reset and clear empty the heap at
// once. An insert reads and tests the root; if the entry is taken, it then
// does one memory read, compare and write-back per heap level until the
// entry settles. An elect sweeps the memory with one read port per compared
// slot: for each valid slot among slots one to K it counts the valid slots
// of the same class, and it skips each empty slot. Clear and the unused
// mode go straight to the response beat. One request is worked on at a
// time; a new request beat is taken while the previous response beat still
// waits.
// ----------------------------------------------------------------------------
module k_nearest_heap_vote (
   input  logic         clock,
   input  logic         reset,
   knhv_req_if.sink     req_chan,
   knhv_rsp_if.source   rsp_chan
);
   import knhv_pkg::*;

   state_type              state_ff, state_in;
   idx_type                idx_ff, idx_in;
   idx_type                jdx_ff, jdx_in;
   logic [CNT_W-1:0]       ballot_ff, ballot_in;
   logic [CNT_W-1:0]       votes_ff, votes_in;
   logic [CLASS_W-1:0]     best_ff, best_in;
   logic                   any_ff, any_in;
   logic                   accepted_ff, accepted_in;
   logic [HEAP_SLOTS-1:0]  valid_ff, valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   slot_type               item_ff;

   slot_type               slot_mem_ff [HEAP_SLOTS];
   slot_type               rdata_a_ff;
   slot_type               rdata_b_ff;
   idx_type                rd_addr_b_ff;

   logic                   we;
   idx_type                waddr;
   slot_type               wdata;
   idx_type                addr_a;
   idx_type                addr_b;
   logic                   load_rsp;
   logic                   match;
   logic [CNT_W-1:0]       count;
   sift_ctl_type           ctl;

   logic                   rsp_accepted_ff;
   logic [CLASS_W-1:0]     rsp_winner_ff;
   logic [VOTE_W-1:0]      rsp_votes_ff;
   logic                   rsp_found_ff;

   knhv_sift_pick u_sift_pick (
      .node          (idx_ff),
      .left_slot     (rdata_a_ff),
      .right_slot    (rdata_b_ff),
      .slot_valid    (valid_ff),
      .item_distance (item_ff.distance),
      .ctl           (ctl)
   );

   always_ff @(posedge clock) begin
      if (we) begin
         slot_mem_ff[waddr] <= wdata;
      end
      rdata_a_ff   <= slot_mem_ff[addr_a];
      rdata_b_ff   <= slot_mem_ff[addr_b];
      rd_addr_b_ff <= addr_b;
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      jdx_in      = jdx_ff;
      ballot_in   = ballot_ff;
      votes_in    = votes_ff;
      best_in     = best_ff;
      any_in      = any_ff;
      accepted_in = accepted_ff;
      valid_in    = valid_ff;
      we          = 1'b0;
      waddr       = idx_ff;
      wdata       = item_ff;
      addr_a      = '0;
      addr_b      = '0;
      load_rsp    = 1'b0;
      match       = 1'b0;
      count       = ballot_ff;
      req_chan.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               accepted_in = 1'b0;
               best_in     = '0;
               votes_in    = '0;
               any_in      = 1'b0;
               case (mode_type'(req_chan.mode))
                  MODE_INSERT: begin
                     idx_in   = '0;
                     state_in = ST_ROOT;
                  end
                  MODE_ELECT: begin
                     idx_in   = IDX_W'(1);
                     state_in = ST_E_NEXT;
                  end
                  MODE_CLEAR: begin
                     valid_in = '0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_ROOT: begin
            addr_a = child_left(idx_ff);
            addr_b = child_right(idx_ff);
            if (valid_ff[0] && (rdata_a_ff.distance < item_ff.distance)) begin
               state_in = ST_DONE;
            end else begin
               accepted_in = 1'b1;
               state_in    = ST_SIFT;
            end
         end

         ST_SIFT: begin
            addr_a = child_left(ctl.pick);
            addr_b = child_right(ctl.pick);
            we     = 1'b1;
            if (ctl.descend) begin
               wdata            = ctl.pick_right ? rdata_b_ff : rdata_a_ff;
               valid_in[idx_ff] = valid_ff[ctl.pick];
               idx_in           = ctl.pick;
            end else begin
               wdata            = item_ff;
               valid_in[idx_ff] = 1'b1;
               state_in         = ST_DONE;
            end
         end

         ST_E_NEXT: begin
            addr_a = idx_ff;
            addr_b = IDX_W'(1);
            if (valid_ff[idx_ff]) begin
               ballot_in = '0;
               jdx_in    = IDX_W'(2);
               state_in  = ST_E_SCAN;
            end else if (idx_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         ST_E_SCAN: begin
            addr_a = idx_ff;
            addr_b = jdx_ff;
            match  = valid_ff[rd_addr_b_ff] && (rdata_a_ff.cls == rdata_b_ff.cls);
            count  = ballot_ff + CNT_W'(match);
            jdx_in = jdx_ff + IDX_W'(1);
            if (rd_addr_b_ff == LAST_IDX) begin
               // A tie goes to the later slot.
               if (count >= votes_ff) begin
                  best_in  = rdata_a_ff.cls;
                  votes_in = count;
               end
               any_in = 1'b1;
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_E_NEXT;
               end
            end else begin
               ballot_in = count;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         jdx_ff       <= '0;
         ballot_ff    <= '0;
         votes_ff     <= '0;
         best_ff      <= '0;
         any_ff       <= 1'b0;
         accepted_ff  <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         jdx_ff       <= jdx_in;
         ballot_ff    <= ballot_in;
         votes_ff     <= votes_in;
         best_ff      <= best_in;
         any_ff       <= any_in;
         accepted_ff  <= accepted_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff.distance <= req_chan.distance;
         item_ff.cls      <= req_chan.class_id;
      end
      if (load_rsp) begin
         rsp_accepted_ff <= accepted_ff;
         rsp_winner_ff   <= best_ff;
         rsp_votes_ff    <= VOTE_W'(votes_ff);
         rsp_found_ff    <= any_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.accepted     = rsp_accepted_ff;
   assign rsp_chan.winner_class = rsp_winner_ff;
   assign rsp_chan.vote_count   = rsp_votes_ff;
   assign rsp_chan.found        = rsp_found_ff;

endmodule

FILE: rtl/knhv_sift_pick.sv
// ----------------------------------------------------------------------------
// knhv_sift_pick
// One level of the heap sift-down: chooses the child that ranks higher and
// decides whether the travelling entry moves below it.
// ----------------------------------------------------------------------------
module knhv_sift_pick (
   input  knhv_pkg::idx_type                 node,
   input  knhv_pkg::slot_type                left_slot,
   input  knhv_pkg::slot_type                right_slot,
   input  logic [knhv_pkg::HEAP_SLOTS-1:0]   slot_valid,
   input  logic [knhv_pkg::DIST_W-1:0]       item_distance,
   output knhv_pkg::sift_ctl_type            ctl
);
   import knhv_pkg::*;

   localparam logic [IDX_W+1:0] SLOTS_WIDE = (IDX_W + 2)'(HEAP_SLOTS);

   logic [IDX_W+1:0]  left_wide;
   logic [IDX_W+1:0]  right_wide;
   logic              has_left;
   logic              has_right;
   idx_type           left_idx;
   idx_type           right_idx;
   logic              valid_left;
   logic              valid_right;
   logic              right_above;
   logic              pick_valid;
   logic [DIST_W-1:0] pick_dist;

   always_comb begin
      left_wide   = {1'b0, node, 1'b1};
      right_wide  = left_wide + (IDX_W + 2)'(1);
      has_left    = left_wide < SLOTS_WIDE;
      has_right   = right_wide < SLOTS_WIDE;
      left_idx    = left_wide[IDX_W-1:0];
      right_idx   = right_wide[IDX_W-1:0];
      valid_left  = slot_valid[left_idx];
      valid_right = slot_valid[right_idx];

      // An empty slot ranks above any stored distance.
      right_above = has_right &&
                    (!valid_right ||
                     (valid_left && (right_slot.distance > left_slot.distance)));
      pick_valid  = right_above ? valid_right : valid_left;
      pick_dist   = right_above ? right_slot.distance : left_slot.distance;

      ctl.pick_right = right_above;
      ctl.pick       = right_above ? right_idx : left_idx;
      ctl.descend    = has_left && (!pick_valid || (pick_dist > item_distance));
   end

endmodule
